[rtl/core/nrt_pkg.sv]
// package for the named region table: sizes, codes and shared types
`default_nettype none
package nrt_pkg;
  localparam int SLOTS = 64;
  localparam int NAME_BYTES = 8;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int HW_W = $clog2(SLOTS + 1);
  localparam logic [15:0] DEFAULT_BUDGET = 16'd4096;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_FIND = 3'd2;
  localparam logic [2:0] KIND_BEGIN = 3'd3;
  localparam logic [2:0] KIND_NEXT = 3'd4;

  typedef struct packed {
    logic live;
    logic [63:0] name;
    logic [63:0] rect;
  } entry_t;

  typedef struct packed {
    logic       wr;
    logic       kill;
    logic [63:0] name;
    logic [63:0] rect;
  } cell_ctl_t;

  function automatic logic [63:0] norm_name(input logic [63:0] key);
    logic [63:0] r;
    logic stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (key[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = key[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [3:0] key_length(input logic [63:0] key);
    logic [3:0] n;
    logic stop;
    n = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (key[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) n = n + 4'd1;
    end
    return n;
  endfunction
endpackage
`default_nettype wire

[rtl/core/nrt_cell.sv]
// one table cell: holds an entry and passes the entry of its neighbor along the ring
`default_nettype none
module nrt_cell import nrt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire logic   at_head,
  input  wire cell_ctl_t ctl,
  input  wire entry_t prev,
  output entry_t      cur
);
  logic [63:0] ent_name, ent_rect;
  logic live;
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (at_head && ctl.wr) begin
      live <= 1'b1;
    end else if (at_head && ctl.kill) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= prev.live;
    end
  end
  always_ff @(posedge clk) begin
    if (at_head && ctl.wr) begin
      ent_name <= ctl.name;
      ent_rect <= ctl.rect;
    end else if (shift) begin
      ent_name <= prev.name;
      ent_rect <= prev.rect;
    end
  end
  assign cur = '{live: live, name: ent_name, rect: ent_rect};
endmodule
`default_nettype wire

[rtl/core/nrt_ring.sv]
// ring of cells rotating once per scan; the head cell is read and written
`default_nettype none
module nrt_ring import nrt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      shift,
  input  wire cell_ctl_t ctl,
  output entry_t         head
);
  entry_t c [SLOTS];
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    nrt_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift), .at_head(i == 0), .ctl(ctl),
      .prev(c[(i + 1) % SLOTS]), .cur(c[i])
    );
  end
  assign head = c[0];
endmodule
`default_nettype wire

[rtl/core/named_region_table_unit.sv]
// top level of the named region table
// channel  dir  tdata (low bit up)                            tuser/tlast
// s_axis   in   name_key 64, in_x, in_y, in_w, in_h 16 each    tuser: kind 3
// m_axis   out  slot_index 6, out_name 64, x, y, w, h 16 each  tuser: ok 1
// cfg      in   name_budget 16 on cfg_wdata when cfg_we
// every request rotates the cell ring one full turn, through all SLOTS slots;
// the ring shift register sets the length of that turn
// an add or remove on a slot other than 0 lands in the next turn, which pauses the ring at that slot
// reset is synchronous and clears all live bits, high water, budget use and cursor
// a stalled result holds the finish step; the next request is taken meanwhile
`default_nettype none
module named_region_table_unit import nrt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [127:0] s_axis_tdata, // name_key, in_x, in_y, in_w, in_h
  input  wire logic [2:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [135:0]     m_axis_tdata,  // slot_index, out_name, x, y, w, h, pad
  output logic             m_axis_tuser,  // ok
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_SCAN = 3'b010, ST_FIN = 3'b100
  } state_t;
  state_t state;
  logic [15:0] budget, used;
  logic [HW_W-1:0] high_water, cursor;
  logic [IDX_W:0] step;
  logic [IDX_W-1:0] pos;
  logic [2:0] kind;
  logic [63:0] name, rect;
  logic [3:0] len;
  logic found, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;
  entry_t head;
  cell_ctl_t ctl;
  logic shift, in_fire, fin_go;
  logic [16:0] charge;
  logic [15:0] limit;
  logic add_ok;
  logic [IDX_W-1:0] add_idx;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign fin_go = (state == ST_FIN) && (!m_axis_tvalid || m_axis_tready);
  assign shift = (state == ST_SCAN);
  assign pos = step[IDX_W-1:0];
  assign limit = (budget == 16'd0) ? DEFAULT_BUDGET : budget;
  assign charge = {1'b0, used} + {13'd0, len} + 17'd1;
  assign add_ok = (len != 4'd0) && (charge <= {1'b0, limit}) && !found &&
                  (free_found || (high_water < HW_W'(SLOTS)));
  assign add_idx = free_found ? free_idx : high_water[IDX_W-1:0];

  // head cell holds slot pos during scan; writes to slot 0 land when the ring is back at slot 0
  always_comb begin
    ctl = '0;
    ctl.name = name;
    ctl.rect = rect;
    if (fin_go) begin
      if (kind == KIND_ADD && add_ok && add_idx == '0) ctl.wr = 1'b1;
      if (kind == KIND_REMOVE && found && hit_idx == '0) ctl.kill = 1'b1;
    end
  end

  // pending write for nonzero slots is applied in the next turn, when the head holds that slot
  logic pend;
  logic [IDX_W-1:0] pend_idx;
  logic pend_wr;
  logic [63:0] pend_name, pend_rect;
  cell_ctl_t ctl2;
  always_comb begin
    ctl2 = ctl;
    if (pend && state == ST_SCAN && pos == pend_idx) begin
      ctl2.wr = pend_wr;
      ctl2.kill = !pend_wr;
      ctl2.name = pend_name;
      ctl2.rect = pend_rect;
    end
  end

  nrt_ring u_ring (.clk(clk), .rst(rst), .shift(shift && !(pend && pos == pend_idx)),
                   .ctl(ctl2), .head(head));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      budget <= DEFAULT_BUDGET;
      used <= '0;
      high_water <= '0;
      cursor <= '0;
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
      step <= '0;
    end else begin
      if (cfg_we) budget <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready && !fin_go) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            kind <= s_axis_tuser;
            name <= norm_name(s_axis_tdata[63:0]);
            len <= key_length(s_axis_tdata[63:0]);
            rect <= s_axis_tdata[127:64];
            found <= 1'b0;
            free_found <= 1'b0;
            step <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend && pos == pend_idx) begin
            pend <= 1'b0;
          end else begin
            if (kind != KIND_NEXT && HW_W'(pos) < high_water && head.live &&
                head.name == name && name != '0 && !found) begin
              found <= 1'b1;
              hit_idx <= pos;
              if (kind == KIND_FIND) rect <= head.rect;
            end
            if (HW_W'(pos) < high_water && !head.live && !free_found) begin
              free_found <= 1'b1;
              free_idx <= pos;
            end
            if (kind == KIND_NEXT && !found && HW_W'(pos) >= cursor &&
                HW_W'(pos) < high_water && head.live) begin
              found <= 1'b1;
              hit_idx <= pos;
              name <= head.name;
              rect <= head.rect;
            end
            if (step == (IDX_W+1)'(SLOTS - 1)) state <= ST_FIN;
            step <= step + 1'b1;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= 1'b0;
            m_axis_tdata <= '0;
            state <= ST_IDLE;
            case (kind)
              KIND_ADD: if (add_ok) begin
                m_axis_tuser <= 1'b1;
                m_axis_tdata[IDX_W-1:0] <= add_idx;
                used <= charge[15:0];
                if (!free_found) high_water <= high_water + 1'b1;
                if (add_idx != '0) begin
                  pend <= 1'b1; pend_idx <= add_idx; pend_wr <= 1'b1;
                  pend_name <= name; pend_rect <= rect;
                end
              end
              KIND_REMOVE: if (found) begin
                m_axis_tuser <= 1'b1;
                m_axis_tdata[IDX_W-1:0] <= hit_idx;
                if (hit_idx != '0) begin
                  pend <= 1'b1; pend_idx <= hit_idx; pend_wr <= 1'b0;
                end
              end
              KIND_FIND: if (found) begin
                m_axis_tuser <= 1'b1;
                m_axis_tdata[IDX_W-1:0] <= hit_idx;
                m_axis_tdata[133:70] <= rect;
              end
              KIND_BEGIN: begin
                m_axis_tuser <= 1'b1;
                cursor <= '0;
              end
              KIND_NEXT: begin
                if (found) begin
                  m_axis_tuser <= 1'b1;
                  m_axis_tdata[IDX_W-1:0] <= hit_idx;
                  m_axis_tdata[69:6] <= name;
                  m_axis_tdata[133:70] <= rect;
                  cursor <= HW_W'(hit_idx) + 1'b1;
                end else begin
                  cursor <= high_water;
                end
              end
              default: ;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/nrt_checker.sv]
// port checker for the named region table, bound to the top level
`default_nettype none
module nrt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [135:0] m_axis_tdata,
  input wire logic m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failure result carries data");
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back transfer");
endmodule
bind named_region_table_unit nrt_checker u_nrt_checker (.*);
`default_nettype wire

[test/tb.sv]
// testbench for the named region table: scoreboard predictor, random and directed requests
`timescale 1ns / 1ps
`default_nettype none

class region_scoreboard;
  logic [15:0] budget_limit;
  bit          live [nrt_pkg::SLOTS];
  logic [63:0] names [nrt_pkg::SLOTS];
  logic [63:0] rects [nrt_pkg::SLOTS];
  int          high_water;
  int          budget_used;
  int          cursor;
  logic [136:0] pending [$];
  int          errors;

  function new();
    budget_limit = nrt_pkg::DEFAULT_BUDGET;
    foreach (live[i]) live[i] = 0;
    high_water = 0;
    budget_used = 0;
    cursor = 0;
    errors = 0;
  endfunction

  function int lookup(logic [63:0] nm);
    if (nm == 0) return -1;
    for (int i = 0; i < high_water; i++)
      if (live[i] && names[i] == nm) return i;
    return -1;
  endfunction

  function void note_request(logic [2:0] kind, logic [127:0] data);
    logic [63:0] nm;
    int len;
    int lim;
    int hit;
    int slot;
    bit ok;
    logic [5:0] idx;
    logic [63:0] oname;
    logic [63:0] orect;
    nm = 0;
    len = 0;
    for (int i = 0; i < 8; i++) begin
      if (data[8*i +: 8] == 0) break;
      nm[8*i +: 8] = data[8*i +: 8];
      len++;
    end
    ok = 0; idx = 0; oname = 0; orect = 0;
    case (kind)
      nrt_pkg::KIND_ADD: begin
        lim = (budget_limit == 0) ? nrt_pkg::DEFAULT_BUDGET : budget_limit;
        if (len != 0 && budget_used + len + 1 <= lim && lookup(nm) < 0) begin
          for (slot = 0; slot < high_water; slot++) if (!live[slot]) break;
          if (slot < high_water || high_water < nrt_pkg::SLOTS) begin
            if (slot >= high_water) high_water++;
            budget_used = (budget_used + len + 1) & 16'hffff;
            names[slot] = nm;
            rects[slot] = data[127:64];
            live[slot] = 1;
            ok = 1;
            idx = 6'(slot);
          end
        end
      end
      nrt_pkg::KIND_REMOVE: begin
        hit = lookup(nm);
        if (hit >= 0) begin
          live[hit] = 0;
          ok = 1;
          idx = 6'(hit);
        end
      end
      nrt_pkg::KIND_FIND: begin
        hit = lookup(nm);
        if (hit >= 0) begin
          ok = 1;
          idx = 6'(hit);
          orect = rects[hit];
        end
      end
      nrt_pkg::KIND_BEGIN: begin
        cursor = 0;
        ok = 1;
      end
      nrt_pkg::KIND_NEXT: begin
        while (cursor < high_water) begin
          slot = cursor;
          cursor++;
          if (live[slot]) begin
            ok = 1;
            idx = 6'(slot);
            oname = names[slot];
            orect = rects[slot];
            break;
          end
        end
      end
      default: ;
    endcase
    pending.push_back({ok, 2'd0, orect, oname, idx});
  endfunction

  function void check_result(logic ok, logic [135:0] data);
    logic [136:0] e;
    if (pending.size() == 0) begin
      $error("result with none expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (ok !== e[136]) begin
      $error("ok exp %0h got %0h", e[136], ok); errors++;
    end
    if (data[5:0] !== e[5:0]) begin
      $error("slot_index exp %0h got %0h", e[5:0], data[5:0]); errors++;
    end
    if (data[69:6] !== e[69:6]) begin
      $error("out_name exp %0h got %0h", e[69:6], data[69:6]); errors++;
    end
    if (data[85:70] !== e[85:70]) begin
      $error("out_x exp %0h got %0h", e[85:70], data[85:70]); errors++;
    end
    if (data[101:86] !== e[101:86]) begin
      $error("out_y exp %0h got %0h", e[101:86], data[101:86]); errors++;
    end
    if (data[117:102] !== e[117:102]) begin
      $error("out_w exp %0h got %0h", e[117:102], data[117:102]); errors++;
    end
    if (data[133:118] !== e[133:118]) begin
      $error("out_h exp %0h got %0h", e[133:118], data[133:118]); errors++;
    end
    if (data[135:134] !== 0) begin
      $error("pad exp 0 got %0h", data[135:134]); errors++;
    end
  endfunction
endclass

module tb;
  import nrt_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = 0;
  logic [2:0] s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [135:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = 0;

  region_scoreboard board;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold = 0;
  event hold_start;
  longint cycle_count = 0;
  logic [63:0] name_pool [16];

  named_region_table_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial board = new();

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver stall
  always begin
    @(hold_start);
    hold <= 1;
    repeat (600) @(posedge clk);
    hold <= 0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tuser, m_axis_tdata);
    if (hold) begin
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [127:0] data);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(kind, data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_budget(input logic [15:0] value);
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.budget_limit = value;
  endtask

  function automatic logic [63:0] make_name();
    logic [63:0] nm;
    int len;
    nm = {$urandom, $urandom};
    if ($urandom_range(9) < 8) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < 8; i++)
        if (i >= len) nm[8*i +: 8] = 0;
        else if (nm[8*i +: 8] == 0) nm[8*i +: 8] = 8'h41;
      if (len < 8 && $urandom_range(3) == 0) nm[8*len +: 8] = 0;
    end
    return nm;
  endfunction

  task automatic random_request();
    logic [2:0] kind;
    logic [63:0] nm;
    int r;
    r = $urandom_range(99);
    if (r < 35) kind = KIND_ADD;
    else if (r < 50) kind = KIND_REMOVE;
    else if (r < 72) kind = KIND_FIND;
    else if (r < 76) kind = KIND_BEGIN;
    else if (r < 96) kind = KIND_NEXT;
    else kind = 3'($urandom_range(7, 5));
    if ($urandom_range(3) != 0) nm = name_pool[$urandom_range(15)];
    else nm = make_name();
    if ($urandom_range(19) == 0) name_pool[$urandom_range(15)] = make_name();
    send_request(kind, {$urandom, $urandom, nm});
  endtask

  initial begin
    for (int i = 0; i < 16; i++) name_pool[i] = make_name();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(KIND_NEXT, '0);
    send_request(KIND_ADD, '0);
    send_request(KIND_ADD, {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
    send_request(KIND_ADD, {64'h0001_0002_0003_0004, 64'h41});
    send_request(KIND_ADD, {64'h0, 64'h41});
    send_request(KIND_ADD, {64'h5555, 64'h4200_0043});
    send_request(KIND_FIND, 128'h41);
    send_request(KIND_FIND, 128'hff00_0041);
    send_request(KIND_FIND, '0);
    send_request(KIND_REMOVE, '0);
    send_request(KIND_REMOVE, 128'h41);
    send_request(KIND_REMOVE, 128'h41);
    send_request(KIND_ADD, {64'h1234, 64'h44});
    send_request(KIND_BEGIN, '0);
    send_request(KIND_NEXT, '0);
    send_request(KIND_NEXT, '0);
    send_request(KIND_NEXT, '0);
    send_request(KIND_NEXT, '0);
    send_request(3'd5, {128{1'b1}});
    send_request(3'd7, '0);
    write_budget(16'd12);
    send_request(KIND_ADD, {64'h9, 64'h4847_4645});
    send_request(KIND_ADD, 128'h49);
    write_budget(16'd0);
    for (int i = 0; i < 70; i++) send_request(KIND_ADD, {$urandom, $urandom, 32'h0, i + 1000});
    send_request(KIND_BEGIN, '0);
    for (int i = 0; i < 66; i++) send_request(KIND_NEXT, '0);
    for (int i = 0; i < 64; i += 2) send_request(KIND_REMOVE, {96'h0, 32'(i + 1000)});
    write_budget(16'hffff);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 33 : (ph == 1) ? 71 : 0;
      recv_idle = (ph == 0) ? 71 : (ph == 1) ? 33 : 0;
      for (int k = 0; k < 450; k++) begin
        if (k == 100) -> hold_start;
        if (k == 250) drain();
        random_request();
      end
      if (ph == 0) write_budget(16'd1);
      if (ph == 1) write_budget(16'($urandom));
    end
    send_idle = 0;
    drain();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
